[hw/rtl/three_by_three_image_convolution_defines.svh]
// Assertion macros for the 3x3 convolution RTL.
// Used by conv3_fifo, which checks its own internal invariants.
`ifndef THREE_BY_THREE_IMAGE_CONVOLUTION_DEFINES_SVH
`define THREE_BY_THREE_IMAGE_CONVOLUTION_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define CONV3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CONV3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/conv3_pkg.sv]
// Shared types, constants and helper functions of the 3x3 convolution.
// No dependencies; imported by every module of the block but conv3_ram.
`default_nettype none
package conv3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int COEF_BITS_DEF = 12;
  localparam int MAX_HEIGHT    = 4096;
  localparam int FIFO_DEPTH    = 4;
  localparam int PIX_W         = 24;
  localparam int CFG_DATA_W    = 36;
  localparam int RES_W         = 24;
  localparam int TOT_W         = 25;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_CHANNELS_USED = 3'd2,
    REG_KEEP_CHANNELS = 3'd3,
    REG_KERNEL_ROW0   = 3'd4,
    REG_KERNEL_ROW1   = 3'd5,
    REG_KERNEL_ROW2   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [10:0]                frame_width;
    logic [12:0]                frame_height;
    logic [1:0]                 channels_used;
    logic                       keep_channels;
    logic [2:0][CFG_DATA_W-1:0] kernel_row;
  } cfg_t;

  // One queued input: the window after its shift, its position and the
  // set of output pixels it completes (above-left, above, left, current).
  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;
    logic [9:0]            x;
    logic [11:0]           y;
    logic [3:0]            mask;
  } fifo_entry_t;

  // Window row or column for tap k around pos, clamped to the frame edge.
  function automatic logic [1:0] tap_idx(input logic [1:0] k, input logic [11:0] pos,
                                         input logic [11:0] cur);
    logic signed [14:0] t;
    logic signed [14:0] idx;
    t = $signed({3'b000, pos}) + $signed({13'd0, k}) - 15'sd1;
    if (t < 15'sd0) t = 15'sd0;
    if (t > $signed({3'b000, cur})) t = $signed({3'b000, cur});
    idx = t - $signed({3'b000, cur}) + 15'sd2;
    if (idx < 15'sd0) idx = 15'sd0;
    if (idx > 15'sd2) idx = 15'sd2;
    return idx[1:0];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/three_by_three_image_convolution.sv]
// 3x3 image correlation with replicated borders over up to three channels.
// Channels: pixels enter on the s_axis word (one pixel of three 8-bit
// samples per word, raster order); results leave on the m_axis word.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write it only while idle, the block does not enforce this. Each pixel
// completes zero to four output pixels; tlast marks the final result of one
// input and tuser marks the bottom-right pixel of a frame. Throughput: one
// input word per cycle while the queue has room; the back end issues the
// outputs of an input one at a time, and the four-entry queue absorbs the
// bursts at the right edge and bottom row. After the input register with
// line-store read, a result passes the queue write, tap select, multiply,
// adder tree and output register.
// Reset clears counters, the window and the queue, and loads a centre-only
// kernel of weight 256, a 1024 x 1024 frame and three kept channels.
// When the receiver stalls, the output word holds, the back end pipeline
// stops, the queue fills and then s_axis_tready_o drops.
// Uses conv3_pkg, conv3_front, conv3_fifo, conv3_back.
`default_nettype none
module three_by_three_image_convolution import conv3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // pix_ch0, pix_ch1, pix_ch2
  input  wire logic [23:0]           s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // out_col, out_row, res_ch0, res_ch1, res_ch2, res_total, one zero bit
  output logic [119:0]               m_axis_tdata_o,
  output logic                       m_axis_tlast_o,
  // end_of_frame
  output logic                       m_axis_tuser_o
);

  cfg_t        cfg_q;
  fifo_entry_t push_entry, head;
  logic        push, full, pop, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= 11'd1024;
      cfg_q.frame_height  <= 13'd1024;
      cfg_q.channels_used <= 2'd3;
      cfg_q.keep_channels <= 1'b1;
      cfg_q.kernel_row[0] <= '0;
      cfg_q.kernel_row[1] <= 36'd1048576;
      cfg_q.kernel_row[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data_i[10:0];
        REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_data_i[12:0];
        REG_CHANNELS_USED: cfg_q.channels_used <= cfg_data_i[1:0];
        REG_KEEP_CHANNELS: cfg_q.keep_channels <= cfg_data_i[0];
        REG_KERNEL_ROW0:   cfg_q.kernel_row[0] <= cfg_data_i;
        REG_KERNEL_ROW1:   cfg_q.kernel_row[1] <= cfg_data_i;
        REG_KERNEL_ROW2:   cfg_q.kernel_row[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  conv3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_pix_i   (s_axis_tdata_i),
    .push_o     (push),
    .full_i     (full),
    .entry_o    (push_entry)
  );

  conv3_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  conv3_back #(.COEF_BITS(COEF_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .head_i    (head),
    .empty_i   (empty),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o),
    .m_eof_o   (m_axis_tuser_o)
  );

endmodule
`default_nettype wire

[hw/rtl/conv3_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`default_nettype none
module conv3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/conv3_front.sv]
// Front end: accepts pixels, keeps counters, line stores and the window,
// and queues each input that completes windows. Uses conv3_pkg, conv3_ram.
`default_nettype none
module conv3_front import conv3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [23:0] in_pix_i,
  output logic             push_o,
  input  wire logic        full_i,
  output fifo_entry_t      entry_o
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [9:0]  x_q, x_d;
  logic [11:0] y_q, y_d;
  logic [12:0] w_eff, h_eff;
  logic        lastc, lastr, accept;
  logic [AW-1:0] xi;

  logic                 p_valid_q, p_valid_d, p_fire, p_hz_q;
  logic [23:0]          p_px_q;
  logic [9:0]           p_x_q;
  logic [11:0]          p_y_q;
  logic [3:0]           p_mask_q;
  logic [AW-1:0]        p_xi_q;
  logic [23:0]          fwd_px_q, fwd_above_q;
  logic [23:0]          prev_rdata, older_rdata, above, older;
  logic [8:0][PIX_W-1:0] win_q, win_d;

  always_comb begin
    if (cfg_i.frame_width == 11'd0) begin
      w_eff = 13'd1;
    end else if ({2'b00, cfg_i.frame_width} > 13'(MAX_WIDTH)) begin
      w_eff = 13'(MAX_WIDTH);
    end else begin
      w_eff = {2'b00, cfg_i.frame_width};
    end
    if (cfg_i.frame_height == 13'd0) begin
      h_eff = 13'd1;
    end else if (cfg_i.frame_height > 13'(MAX_HEIGHT)) begin
      h_eff = 13'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_i.frame_height;
    end
  end

  assign lastc = {3'b000, x_q} >= (w_eff - 13'd1);
  assign lastr = {1'b0, y_q} >= (h_eff - 13'd1);
  assign xi    = ({3'b000, x_q} < 13'(MAX_WIDTH)) ? AW'({3'b000, x_q}) : AW'(MAX_WIDTH - 1);

  assign accept     = in_valid_i && in_ready_o;
  assign p_fire     = p_valid_q && (!(|p_mask_q) || !full_i);
  assign in_ready_o = !p_valid_q || p_fire;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (accept) begin
      if (lastc) begin
        x_d = '0;
        y_d = lastr ? '0 : y_q + 12'd1;
      end else begin
        x_d = x_q + 10'd1;
      end
    end
  end

  assign p_valid_d = accept ? 1'b1 : (p_fire ? 1'b0 : p_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= '0;
      y_q       <= '0;
      p_valid_q <= 1'b0;
      win_q     <= '0;
    end else begin
      x_q       <= x_d;
      y_q       <= y_d;
      p_valid_q <= p_valid_d;
      win_q     <= win_d;
    end
  end

  // A read issued in the same cycle as a write to the same entry sees the
  // old data, so the written values are forwarded.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_px_q   <= in_pix_i;
      p_x_q    <= x_q;
      p_y_q    <= y_q;
      p_xi_q   <= xi;
      p_hz_q   <= p_fire && (p_xi_q == xi);
      p_mask_q <= {lastr && lastc, lastr && (x_q != 10'd0),
                   (y_q != 12'd0) && lastc, (y_q != 12'd0) && (x_q != 10'd0)};
    end
    if (p_fire) begin
      fwd_px_q    <= p_px_q;
      fwd_above_q <= above;
    end
  end

  assign above = p_hz_q ? fwd_px_q : prev_rdata;
  assign older = p_hz_q ? fwd_above_q : older_rdata;

  always_comb begin
    win_d = win_q;
    if (p_fire) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r*3]     = win_q[r*3+1];
        win_d[r*3 + 1] = win_q[r*3+2];
      end
      win_d[2] = older;
      win_d[5] = above;
      win_d[8] = p_px_q;
    end
  end

  assign push_o        = p_fire && (|p_mask_q);
  assign entry_o.win   = win_d;
  assign entry_o.x     = p_x_q;
  assign entry_o.y     = p_y_q;
  assign entry_o.mask  = p_mask_q;

  conv3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev (
    .clk_i   (clk_i),
    .we_i    (p_fire),
    .waddr_i (p_xi_q),
    .wdata_i (p_px_q),
    .re_i    (accept),
    .raddr_i (xi),
    .rdata_o (prev_rdata)
  );

  conv3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk_i   (clk_i),
    .we_i    (p_fire),
    .waddr_i (p_xi_q),
    .wdata_i (above),
    .re_i    (accept),
    .raddr_i (xi),
    .rdata_o (older_rdata)
  );

endmodule
`default_nettype wire

[hw/rtl/conv3_fifo.sv]
// Short register queue between the front end and the arithmetic back end.
// Uses conv3_pkg and the assertion macros header.
`default_nettype none
`include "three_by_three_image_convolution_defines.svh"
module conv3_fifo import conv3_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire fifo_entry_t entry_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             empty_o,
  output fifo_entry_t      head_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fifo_entry_t    mem_q [DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  `CONV3_ASSERT(a_no_overflow, !(push_i && full_o), "push into a full queue")
  `CONV3_ASSERT(a_no_underflow, !(pop_i && empty_o), "pop from an empty queue")
  `CONV3_ASSERT_NEXT(a_cnt_track, push_i && !pop_i, cnt_q == $past(cnt_q) + CW'(1), "count lost a push")

endmodule
`default_nettype wire

[hw/rtl/conv3_back.sv]
// Back end: walks the output pixels of each queued input and computes the
// weighted sums in a four-stage pipeline. Uses conv3_pkg.
`default_nettype none
module conv3_back import conv3_pkg::*; #(
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cfg_t         cfg_i,
  input  wire fifo_entry_t  head_i,
  input  wire logic         empty_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  wire logic         m_ready_i,
  output logic [119:0]      m_data_o,
  output logic              m_last_o,
  output logic              m_eof_o
);

  localparam int PW = 9 + COEF_BITS;
  localparam int SW = PW + 4;

  logic        en, issue, started_q, started_d;
  logic [3:0]  mask_q, mask_d, rem, rem_nxt, sel;
  logic [9:0]  col;
  logic [11:0] row;
  logic [1:0]  wr [3];
  logic [1:0]  wc [3];
  logic [1:0]  nch;
  logic signed [COEF_BITS-1:0] coef [3][3];
  logic [63:0] krow [3];

  logic                  s0_v_q, s1_v_q, s2_v_q, out_v_q;
  logic [8:0][PIX_W-1:0] s0_tap_q, s0_tap_d;
  logic [9:0]            s0_col_q, s1_col_q, s2_col_q;
  logic [11:0]           s0_row_q, s1_row_q, s2_row_q;
  logic                  s0_last_q, s1_last_q, s2_last_q;
  logic                  s0_eof_q, s1_eof_q, s2_eof_q;
  logic signed [PW-1:0]  s1_prod_q [3][9];
  logic signed [PW-1:0]  s1_prod_d [3][9];
  logic signed [SW-1:0]  s2_sum_q [3];
  logic signed [SW-1:0]  s2_sum_d [3];
  logic signed [SW+1:0]  total;
  logic [RES_W-1:0]      res_ch [3];
  logic [119:0]          out_data_q, out_data_d;
  logic                  out_last_q, out_eof_q;

  assign en  = !out_v_q || m_ready_i;
  assign nch = (cfg_i.channels_used == 2'd0) ? 2'd1 : cfg_i.channels_used;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      krow[j] = {28'd0, cfg_i.kernel_row[j]};
      for (int i = 0; i < 3; i++) begin
        coef[j][i] = $signed(krow[j][i*COEF_BITS +: COEF_BITS]);
      end
    end
  end

  // Remaining outputs of the head entry, taken lowest first.
  always_comb begin
    rem = started_q ? mask_q : head_i.mask;
    sel = rem & (~rem + 4'd1);
    rem_nxt = rem & ~sel;
    col = (sel[0] || sel[2]) ? head_i.x - 10'd1 : head_i.x;
    row = (sel[0] || sel[1]) ? head_i.y - 12'd1 : head_i.y;
    for (int k = 0; k < 3; k++) begin
      wr[k] = tap_idx(2'(k), row, head_i.y);
      wc[k] = tap_idx(2'(k), {2'b00, col}, {2'b00, head_i.x});
    end
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        s0_tap_d[j*3+i] = head_i.win[4'(wr[j]) * 4'd3 + 4'(wc[i])];
      end
    end
  end

  assign issue = !empty_i && en;
  assign pop_o = issue && (rem_nxt == 4'd0);

  always_comb begin
    started_d = started_q;
    mask_d    = mask_q;
    if (issue) begin
      started_d = rem_nxt != 4'd0;
      mask_d    = rem_nxt;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int t = 0; t < 9; t++) begin
        s1_prod_d[c][t] = $signed({{(COEF_BITS+1){1'b0}}, s0_tap_q[t][c*8 +: 8]}) *
                          PW'(coef[t/3][t%3]);
      end
    end
    for (int c = 0; c < 3; c++) begin
      s2_sum_d[c] = '0;
      for (int t = 0; t < 9; t++) begin
        s2_sum_d[c] = s2_sum_d[c] + SW'(s1_prod_q[c][t]);
      end
    end
    total = '0;
    for (int c = 0; c < 3; c++) begin
      if (2'(c) < nch) total = total + (SW+2)'(s2_sum_q[c]);
      res_ch[c] = (cfg_i.keep_channels && (2'(c) < nch)) ? s2_sum_q[c][RES_W-1:0] : '0;
    end
    out_data_d = {1'b0, cfg_i.keep_channels ? {TOT_W{1'b0}} : total[TOT_W-1:0],
                  res_ch[2], res_ch[1], res_ch[0], s2_row_q, s2_col_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      mask_q    <= '0;
      s0_v_q    <= 1'b0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      started_q <= started_d;
      mask_q    <= mask_d;
      if (en) begin
        s0_v_q  <= issue;
        s1_v_q  <= s0_v_q;
        s2_v_q  <= s1_v_q;
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_tap_q   <= s0_tap_d;
      s0_col_q   <= col;
      s0_row_q   <= row;
      s0_last_q  <= rem_nxt == 4'd0;
      s0_eof_q   <= sel[3];
      s1_prod_q  <= s1_prod_d;
      s1_col_q   <= s0_col_q;
      s1_row_q   <= s0_row_q;
      s1_last_q  <= s0_last_q;
      s1_eof_q   <= s0_eof_q;
      s2_sum_q   <= s2_sum_d;
      s2_col_q   <= s1_col_q;
      s2_row_q   <= s1_row_q;
      s2_last_q  <= s1_last_q;
      s2_eof_q   <= s1_eof_q;
      out_data_q <= out_data_d;
      out_last_q <= s2_last_q;
      out_eof_q  <= s2_eof_q;
    end
  end

  assign m_valid_o = out_v_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;
  assign m_eof_o   = out_eof_q;

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for three_by_three_image_convolution: streams pixel frames
// and compares every result word against a window-and-kernel predictor kept in a class.
// Depends on conv3_pkg and the three_by_three_image_convolution RTL.
`default_nettype none
module tb_top;
  import conv3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [9:0]  col;
    logic [11:0] row;
    logic [23:0] ch [3];
    logic [24:0] total;
    bit          last;
    bit          eof;
  } conv_pixel_t;

  class conv_scoreboard;
    logic [10:0] frame_width;
    logic [12:0] frame_height;
    logic [1:0]  chans;
    bit          keep;
    logic [35:0] krow [3];
    logic [23:0] prev_line [1024];
    logic [23:0] older_line [1024];
    logic [23:0] win [9];
    int unsigned col, row;
    conv_pixel_t pending [$];
    int          errors;

    function new();
      frame_width = 11'd1024;
      frame_height = 13'd1024;
      chans = 2'd3;
      keep = 1'b1;
      krow[0] = '0;
      krow[1] = 36'd1048576;
      krow[2] = '0;
      foreach (prev_line[i]) begin
        prev_line[i] = '0;
        older_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col = 0;
      row = 0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [35:0] v);
      case (idx)
        REG_FRAME_WIDTH:   frame_width = v[10:0];
        REG_FRAME_HEIGHT:  frame_height = v[12:0];
        REG_CHANNELS_USED: chans = v[1:0];
        REG_KEEP_CHANNELS: keep = v[0];
        REG_KERNEL_ROW0:   krow[0] = v;
        REG_KERNEL_ROW1:   krow[1] = v;
        REG_KERNEL_ROW2:   krow[2] = v;
        default: ;
      endcase
    endfunction

    function int eff_width();
      if (frame_width == 0) return 1;
      return (frame_width > 1024) ? 1024 : int'(frame_width);
    endfunction

    function int eff_height();
      if (frame_height == 0) return 1;
      return (frame_height > 4096) ? 4096 : int'(frame_height);
    endfunction

    function int coef(int r, int c);
      logic signed [11:0] raw;
      raw = krow[r][c*12 +: 12];
      return int'(raw);
    endfunction

    // Window slot for tap k around pos, with the frame edge replicated.
    function int tap(int k, int pos, int cur);
      int t;
      t = pos + k - 1;
      if (t < 0) t = 0;
      if (t > cur) t = cur;
      t = t - cur + 2;
      if (t < 0) t = 0;
      if (t > 2) t = 2;
      return t;
    endfunction

    function void add_result(int c, int r, int x, int y, int nch, bit eof);
      int          s [3];
      int          tot;
      logic [23:0] px;
      conv_pixel_t e;
      s = '{0, 0, 0};
      tot = 0;
      for (int j = 0; j < 3; j++)
        for (int i = 0; i < 3; i++) begin
          px = win[tap(j, r, y) * 3 + tap(i, c, x)];
          for (int ch = 0; ch < 3; ch++)
            s[ch] += int'(px[8*ch +: 8]) * coef(j, i);
        end
      e.col = c[9:0];
      e.row = r[11:0];
      for (int ch = 0; ch < 3; ch++) begin
        if (ch < nch) tot += s[ch];
        e.ch[ch] = (keep && ch < nch) ? s[ch][23:0] : 24'd0;
      end
      e.total = keep ? 25'd0 : tot[24:0];
      e.last = 1'b0;
      e.eof = eof;
      pending.push_back(e);
    endfunction

    function void note_pixel(logic [23:0] px);
      int w, h, nch, x, y, xi, n, r;
      bit lastc, lastr;
      logic [23:0] above, older;
      w = eff_width();
      h = eff_height();
      nch = (chans == 0) ? 1 : int'(chans);
      x = col;
      y = row;
      lastc = x >= w - 1;
      lastr = y >= h - 1;
      xi = (x < 1024) ? x : 1023;
      above = prev_line[xi];
      older = older_line[xi];
      for (int k = 0; k < 3; k++) begin
        win[k*3] = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2] = older;
      win[5] = above;
      win[8] = px;
      older_line[xi] = above;
      prev_line[xi] = px;
      n = 0;
      // Rows are completed top first: the row above, then on the bottom row the row itself.
      for (int pass = 0; pass < 2; pass++) begin
        if (pass == 0 && y < 1) continue;
        if (pass == 1 && !lastr) continue;
        r = (pass == 0) ? y - 1 : y;
        if (x >= 1) begin
          add_result(x - 1, r, x, y, nch, 1'b0);
          n++;
        end
        if (lastc) begin
          add_result(x, r, x, y, nch, pass == 1);
          n++;
        end
      end
      if (n > 0) pending[pending.size()-1].last = 1'b1;
      if (lastc) begin
        col = 0;
        row = lastr ? 0 : ((y + 1) & 12'hFFF);
      end else begin
        col = (x + 1) & 10'h3FF;
      end
    endfunction

    function void check_result(logic [119:0] d, bit last, bit eof);
      conv_pixel_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word: data %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[9:0] !== e.col) begin
        $error("out_col: expected %0d, got %0d", e.col, d[9:0]); errors++;
      end
      if (d[21:10] !== e.row) begin
        $error("out_row: expected %0d, got %0d", e.row, d[21:10]); errors++;
      end
      for (int ch = 0; ch < 3; ch++)
        if (d[22+24*ch +: 24] !== e.ch[ch]) begin
          $error("res_ch%0d: expected %h, got %h", ch, e.ch[ch], d[22+24*ch +: 24]);
          errors++;
        end
      if (d[118:94] !== e.total) begin
        $error("res_total: expected %h, got %h", e.total, d[118:94]); errors++;
      end
      if (d[119] !== 1'b0) begin
        $error("pad bit: expected 0, got %b", d[119]); errors++;
      end
      if (last !== e.last) begin
        $error("last_in_run: expected %0d, got %0d", e.last, last); errors++;
      end
      if (eof !== e.eof) begin
        $error("end_of_frame: expected %0d, got %0d", e.eof, eof); errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [35:0]  cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [23:0]  s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [119:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;
  logic         m_axis_tuser_o;

  conv_scoreboard convolution_sb = new();
  int burst_left = 0;
  int sent_cnt = 0;

  three_by_three_image_convolution i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o, .m_axis_tuser_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stall pattern: picks at random, each time stall_cnt wraps, among
  // always ready, coin flip, and mostly stalled.
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(negedge clk_i) begin
    if (stall_cnt == 0) stall_mode <= $urandom_range(0, 2);
    stall_cnt <= (stall_cnt + 1) % 64;
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= $urandom_range(0, 1);
      default: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      convolution_sb.check_result(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Sends one word; bursts of random length are separated by random gaps.
  task automatic send_pixel(logic [23:0] px);
    if (burst_left == 0) begin
      int gap;
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i) s_axis_tvalid_i <= 1'b0;
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= px;
    do @(posedge clk_i); while (!s_axis_tready_o);
    convolution_sb.note_pixel(px);
    sent_cnt++;
  endtask

  task automatic drain();
    @(negedge clk_i) s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (convolution_sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [35:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    convolution_sb.write_reg(idx, v);
  endtask

  // Reconfigures while idle. A wider frame is only set up on a frame boundary,
  // so no line-store entry that was never written is read.
  task automatic setup(logic [10:0] w, logic [12:0] h, logic [1:0] ch, bit keep,
                       logic [35:0] k0, logic [35:0] k1, logic [35:0] k2);
    int new_w;
    new_w = (w == 0) ? 1 : ((w > 1024) ? 1024 : int'(w));
    if (new_w > convolution_sb.eff_width())
      while (convolution_sb.col != 0 || convolution_sb.row != 0)
        send_pixel({$urandom} & 24'hFFFFFF);
    drain();
    write_reg(REG_FRAME_WIDTH, 36'(w));
    write_reg(REG_FRAME_HEIGHT, 36'(h));
    write_reg(REG_CHANNELS_USED, 36'(ch));
    write_reg(REG_KEEP_CHANNELS, 36'(keep));
    write_reg(REG_KERNEL_ROW0, k0);
    write_reg(REG_KERNEL_ROW1, k1);
    write_reg(REG_KERNEL_ROW2, k2);
  endtask

  function automatic logic [35:0] rand_row();
    return {$urandom, $urandom} & 36'hF_FFFF_FFFF;
  endfunction

  initial begin
    int w, h, n;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Reset setup: centre-only kernel of weight 256 on a wide frame, extreme samples.
    for (int i = 0; i < 6; i++) send_pixel((i % 2) ? 24'hFFFFFF : 24'h000000);
    // Narrower frame taken mid-row: the column counter wraps on the next word.
    setup(11'd4, 13'd3, 2'd3, 1'b1, 36'h7FF7FF7FF, 36'h7FF7FF7FF, 36'h7FF7FF7FF);
    for (int i = 0; i < 12; i++) send_pixel(24'hFFFFFF);
    setup(11'd3, 13'd2, 2'd3, 1'b0, 36'h800800800, 36'h800800800, 36'h800800800);
    for (int i = 0; i < 6; i++) send_pixel((i == 2) ? 24'h000000 : 24'hFFFFFF);
    // Zero geometry and zero channels behave as one.
    setup(11'd0, 13'd0, 2'd0, 1'b0, rand_row(), rand_row(), rand_row());
    for (int i = 0; i < 3; i++) send_pixel({$urandom} & 24'hFFFFFF);
    // Oversized width and height saturate.
    setup(11'd2047, 13'd1, 2'd2, 1'b1, rand_row(), rand_row(), rand_row());
    for (int i = 0; i < 40; i++) send_pixel({$urandom} & 24'hFFFFFF);
    setup(11'd1, 13'd8191, 2'd1, 1'b1, rand_row(), rand_row(), rand_row());
    for (int i = 0; i < 40; i++) send_pixel({$urandom} & 24'hFFFFFF);
    // A shorter frame taken below its last row: the row counter wraps on the next word.
    setup(11'd1, 13'd1, 2'd3, 1'b0, rand_row(), rand_row(), rand_row());
    for (int i = 0; i < 2; i++) send_pixel({$urandom} & 24'hFFFFFF);

    while (sent_cnt < 440) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      setup(11'(w), 13'(h), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
            rand_row(), rand_row(), rand_row());
      n = $urandom_range(1, 3) * w * h;
      if ($urandom_range(0, 1)) n += $urandom_range(0, w * h - 1);
      for (int i = 0; i < n; i++) send_pixel({$urandom} & 24'hFFFFFF);
    end
    drain();
    if (convolution_sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
+incdir+hw/rtl
hw/rtl/conv3_pkg.sv
hw/rtl/conv3_ram.sv
hw/rtl/conv3_front.sv
hw/rtl/conv3_fifo.sv
hw/rtl/conv3_back.sv
hw/rtl/three_by_three_image_convolution.sv
tb/tb_top.sv
